@@ hw/rtl/uas_pkg.sv @@
package uas_pkg;

   localparam int DEPTH = 128;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int DW    = 32;

   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   typedef enum logic [1:0] {
      CMD_APPEND     = 2'd0,
      CMD_SEARCH     = 2'd1,
      CMD_REMOVE_AT  = 2'd2,
      CMD_REMOVE_ALL = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_DONE  = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2,
      STS_MISS  = 2'd3
   } status_type;

endpackage

@@ hw/rtl/unsorted_array_store_core.sv @@
// Packed, unsorted list of signed 32-bit values with a fill count.
// A request is taken at a rising edge where start is high and busy is low.
// Commands: append, search for a value, remove at a position, and remove
// every match while keeping the order of the survivors.
// Every request yields exactly one response: rsp_valid is high for one cycle
// and the response fields are valid in that cycle. The receiver cannot stall,
// so it must take each response as it appears.
// Append and every rejected request respond in the cycle after the
// request and leave busy low, so such requests can follow every cycle.
// Search, remove-at and remove-all walk the stored entries through the single
// read port of the entry memory, one entry per cycle, and keep busy high
// until done (remove-at starts at position + 1, and search stops at the first
// match). rsp_valid rises in the same cycle that busy falls.
// A remove rewrites each kept entry at a lower address than the one being
// read, so no read ever sees a pending write.
// Synchronous reset empties the list at once; the memory contents are not
// cleared, since only entries below the fill count are ever used.
module unsorted_array_store_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_cmd,
   input  logic signed [31:0]         req_value,
   input  logic [6:0]                 req_position,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_found,
   output logic [6:0]                 rsp_index,
   output logic [7:0]                 rsp_removed,
   output logic [7:0]                 rsp_fill,
   output logic                       rsp_full_res,
   output logic                       rsp_empty_res
);
   import uas_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          op_ff, op_in;
   logic [DW-1:0]    key_ff, key_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pend_idx_ff, pend_idx_in;
   logic [DW-1:0]    rd_data_ff;

   logic [DW-1:0]    entry_mem [DEPTH];
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [DW-1:0]    mem_wdata;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [6:0]       rsp_index_ff, rsp_index_in;
   logic [7:0]       rsp_removed_ff, rsp_removed_in;
   logic [7:0]       rsp_fill_ff, rsp_fill_in;
   logic             rsp_full_ff, rsp_full_in;
   logic             rsp_empty_ff, rsp_empty_in;

   logic             issue;
   logic [CW-1:0]    pos_ext;

   assign pos_ext = CW'(req_position);
   assign issue   = (state_ff == S_SCAN) && (rd_ptr_ff < count_ff);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      count_in       = count_ff;
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      pend_in        = 1'b0;
      pend_idx_in    = rd_ptr_ff[AW-1:0];
      mem_we         = 1'b0;
      mem_waddr      = wr_ptr_ff[AW-1:0];
      mem_wdata      = rd_data_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = STS_DONE;
      rsp_found_in   = 1'b0;
      rsp_index_in   = '0;
      rsp_removed_in = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = cmd_type'(req_cmd);
               key_in    = req_value;
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               unique case (cmd_type'(req_cmd))
                  CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= DEPTH_CNT) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = req_value;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  CMD_SEARCH: begin
                     state_in = S_SCAN;
                  end
                  CMD_REMOVE_AT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else if (pos_ext >= count_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_MISS;
                     end else begin
                        state_in  = S_SCAN;
                        rd_ptr_in = pos_ext + CW'(1);
                        wr_ptr_in = pos_ext;
                     end
                  end
                  CMD_REMOVE_ALL: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue) begin
               pend_in   = 1'b1;
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
            if (pend_ff) begin
               unique case (op_ff)
                  CMD_SEARCH: begin
                     if (rd_data_ff == key_ff) begin
                        // First match ends the walk; the read in flight is dropped.
                        state_in     = S_IDLE;
                        pend_in      = 1'b0;
                        rsp_valid_in = 1'b1;
                        rsp_found_in = 1'b1;
                        rsp_index_in = 7'(pend_idx_ff);
                     end
                  end
                  CMD_REMOVE_AT: begin
                     mem_we    = 1'b1;
                     wr_ptr_in = wr_ptr_ff + CW'(1);
                  end
                  CMD_REMOVE_ALL: begin
                     if (rd_data_ff != key_ff) begin
                        mem_we    = 1'b1;
                        wr_ptr_in = wr_ptr_ff + CW'(1);
                     end
                  end
                  default: begin
                     mem_we = 1'b0;
                  end
               endcase
            end else if (rd_ptr_ff >= count_ff) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               unique case (op_ff)
                  CMD_REMOVE_AT: begin
                     count_in       = count_ff - CW'(1);
                     rsp_removed_in = 8'd1;
                  end
                  CMD_REMOVE_ALL: begin
                     count_in       = wr_ptr_ff;
                     rsp_removed_in = 8'(count_ff - wr_ptr_ff);
                     if (wr_ptr_ff == count_ff) begin
                        rsp_status_in = STS_MISS;
                     end
                  end
                  default: begin
                     rsp_status_in = STS_MISS;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_fill_in  = 8'(count_in);
      rsp_full_in  = (count_in >= DEPTH_CNT);
      rsp_empty_in = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[rd_ptr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      rd_ptr_ff      <= rd_ptr_in;
      wr_ptr_ff      <= wr_ptr_in;
      pend_idx_ff    <= pend_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_fill_ff    <= rsp_fill_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_index     = rsp_index_ff;
   assign rsp_removed   = rsp_removed_ff;
   assign rsp_fill      = rsp_fill_ff;
   assign rsp_full_res  = rsp_full_ff;
   assign rsp_empty_res = rsp_empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("fill count exceeds the store depth");

   a_write_behind_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (wr_ptr_ff <= rd_ptr_ff))
      else $error("compaction write overtook the read pointer");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor in progress");

   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_res == (rsp_fill == 8'd0)))
      else $error("empty flag disagrees with the fill count");

endmodule
